### rtl/assert_macros.svh
// Assertion macros shared by the stepper step generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/ssg_pkg.sv
// Shared types and constants of the stepper step generator.
`default_nettype none

package ssg_pkg;

  localparam int unsigned POS_BITS_DEF   = 32;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [31:0] INTERVAL_RESET = 32'd1000;

  // Input function codes
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_MOVE_REL = 3'd1;
  localparam logic [2:0] FUNC_MOVE_ABS = 3'd2;
  localparam logic [2:0] FUNC_RUN      = 3'd3;
  localparam logic [2:0] FUNC_STOP     = 3'd4;
  localparam logic [2:0] FUNC_SET_POS  = 3'd5;

  // Result event codes
  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_DONE    = 2'd1;
  localparam logic [1:0] EVT_STOPPED = 2'd2;

  // Register index
  localparam logic REG_INTERVAL = 1'b0;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_MOVE_REL,
    OP_MOVE_ABS,
    OP_RUN,
    OP_STOP,
    OP_SET_POS,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] value;
    logic        run_dir;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

endpackage

`default_nettype wire

### rtl/ssg_front.sv
// Front end: accepts input items and classifies them into commands.
`default_nettype none

module ssg_front (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         func_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               run_direction_i,
  input  wire logic               q_full_i,
  output ssg_pkg::push_t          push_o
);

  ssg_pkg::op_e op;

  always_comb begin
    case (func_i)
      ssg_pkg::FUNC_TICK:     op = ssg_pkg::OP_TICK;
      ssg_pkg::FUNC_MOVE_REL: op = ssg_pkg::OP_MOVE_REL;
      ssg_pkg::FUNC_MOVE_ABS: op = ssg_pkg::OP_MOVE_ABS;
      ssg_pkg::FUNC_RUN:      op = ssg_pkg::OP_RUN;
      ssg_pkg::FUNC_STOP:     op = ssg_pkg::OP_STOP;
      ssg_pkg::FUNC_SET_POS:  op = ssg_pkg::OP_SET_POS;
      default:                op = ssg_pkg::OP_NOP;
    endcase
  end

  assign in_stall_o          = q_full_i;
  assign push_o.valid        = in_valid_i & ~q_full_i;
  assign push_o.cmd.op       = op;
  assign push_o.cmd.value    = $unsigned(value_i);
  assign push_o.cmd.run_dir  = run_direction_i;

endmodule

`default_nettype wire

### rtl/ssg_queue.sv
// Short command queue between the front end and the execution unit.
`default_nettype none
`include "assert_macros.svh"

module ssg_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ssg_pkg::push_t push_i,
  input  wire logic           pop_i,
  output logic                head_valid_o,
  output ssg_pkg::cmd_t       head_o,
  output logic                full_o
);

  localparam int unsigned Depth  = ssg_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  ssg_pkg::cmd_t       entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0]   count_q, count_d;
  logic                do_pop;

  assign head_valid_o = (count_q != '0);
  assign full_o       = (count_q == CountW'(Depth));
  assign head_o       = entry_q[rd_ptr_q];
  assign do_pop       = pop_i & head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i.valid) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i.valid && !do_pop) begin
      count_d = count_q + CountW'(1);
    end else if (!push_i.valid && do_pop) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  `ASSERT_NEVER(a_no_push_when_full, push_i.valid && full_o, "push into full queue")
  `ASSERT_NEVER(a_count_bound, count_q > CountW'(Depth), "queue count beyond depth")
  `ASSERT_ALWAYS(a_pop_only_valid, pop_i && !head_valid_o |=> count_q == $past(count_q) + CountW'($past(push_i.valid)), "pop of empty queue changed count")

endmodule

`default_nettype wire

### rtl/ssg_back.sv
// Execution unit: motion state, step timing and the registered result.
`default_nettype none
`include "assert_macros.svh"

module ssg_back #(
  parameter int unsigned POS_BITS = ssg_pkg::POS_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire ssg_pkg::cmd_t head_i,
  output logic               pop_o,
  input  wire logic [31:0]   interval_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               step_pulse_o,
  output logic               direction_out_o,
  output logic signed [31:0] actual_position_o,
  output logic               moving_o,
  output logic [1:0]         event_res_o,
  output logic               error_o
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_POSITION,
    MODE_VELOCITY
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [31:0]         rem_q, rem_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                dir_q, dir_d;
  logic [31:0]         cnt_q, cnt_d;

  logic                out_valid_q;
  logic                pulse_q, pulse_d;
  logic [1:0]          evt_q, evt_d;
  logic                err_q, err_d;

  logic [31:0] pos_low;
  logic [31:0] cnt_abs, cnt_abs_neg, move_cnt, move_neg;

  assign pop_o   = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pos_low = 32'(pos_q);

  // Both signs computed side by side so the magnitude needs no second add
  assign cnt_abs     = head_i.value - pos_low;
  assign cnt_abs_neg = pos_low - head_i.value;
  assign move_cnt    = (head_i.op == ssg_pkg::OP_MOVE_ABS) ? cnt_abs : head_i.value;
  assign move_neg    = (head_i.op == ssg_pkg::OP_MOVE_ABS) ? cnt_abs_neg
                                                           : 32'd0 - head_i.value;

  always_comb begin
    mode_d  = mode_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    dir_d   = dir_q;
    cnt_d   = cnt_q;
    pulse_d = 1'b0;
    evt_d   = ssg_pkg::EVT_NONE;
    err_d   = 1'b0;
    case (head_i.op)
      ssg_pkg::OP_TICK: begin
        if (mode_q != MODE_IDLE) begin
          if (cnt_q > 32'd1) begin
            cnt_d = cnt_q - 32'd1;
          end else begin
            pulse_d = 1'b1;
            pos_d   = dir_q ? pos_q + POS_BITS'(1) : pos_q - POS_BITS'(1);
            cnt_d   = interval_i;
            if (mode_q == MODE_POSITION) begin
              rem_d = rem_q - 32'd1;
              if (rem_q == 32'd1) begin
                mode_d = MODE_IDLE;
                cnt_d  = 32'd0;
                evt_d  = ssg_pkg::EVT_DONE;
              end
            end
          end
        end
      end
      ssg_pkg::OP_MOVE_REL, ssg_pkg::OP_MOVE_ABS: begin
        if (interval_i == 32'd0) begin
          err_d = 1'b1;
        end else if (move_cnt == 32'd0) begin
          // zero-length move completes at once and keeps the direction
          mode_d = MODE_IDLE;
          rem_d  = 32'd0;
          cnt_d  = 32'd0;
          evt_d  = ssg_pkg::EVT_DONE;
        end else begin
          dir_d  = ~move_cnt[31];
          rem_d  = move_cnt[31] ? move_neg : move_cnt;
          mode_d = MODE_POSITION;
          cnt_d  = 32'd1;
        end
      end
      ssg_pkg::OP_RUN: begin
        mode_d = MODE_VELOCITY;
        dir_d  = head_i.run_dir;
        cnt_d  = 32'd1;
      end
      ssg_pkg::OP_STOP: begin
        mode_d = MODE_IDLE;
        rem_d  = 32'd0;
        cnt_d  = 32'd0;
        evt_d  = ssg_pkg::EVT_STOPPED;
      end
      ssg_pkg::OP_SET_POS: begin
        pos_d = POS_BITS'($signed(head_i.value));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      rem_q       <= '0;
      pos_q       <= '0;
      dir_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        mode_q <= mode_d;
        rem_q  <= rem_d;
        pos_q  <= pos_d;
        dir_q  <= dir_d;
        cnt_q  <= cnt_d;
      end
      out_valid_q <= pop_o | (out_valid_q & out_stall_i);
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pulse_q <= pulse_d;
      evt_q   <= evt_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign step_pulse_o      = pulse_q;
  assign event_res_o       = evt_q;
  assign error_o           = err_q;
  assign direction_out_o   = dir_q;
  assign moving_o          = (mode_q != MODE_IDLE);
  assign actual_position_o = 32'($signed(pos_q));

  `ASSERT_ALWAYS(a_idle_count_clear, mode_q == MODE_IDLE |-> cnt_q == 32'd0, "idle with armed countdown")
  `ASSERT_ALWAYS(a_error_alone, out_valid_q && err_q |-> !pulse_q && evt_q == ssg_pkg::EVT_NONE, "rejected move gave a step or event")
  `ASSERT_ALWAYS(a_pos_hold, pop_o && head_i.op != ssg_pkg::OP_TICK && head_i.op != ssg_pkg::OP_SET_POS |=> pos_q == $past(pos_q), "position moved without tick or set")
  `ASSERT_ALWAYS(a_position_rem, mode_q == MODE_POSITION |-> rem_q != 32'd0, "position mode with no steps left")

endmodule

`default_nettype wire

### rtl/stepper_step_generator_top.sv
// Stepper step generator: front end, command queue, execution unit, APB register.
// Inputs are held in the queue, results in the execution unit's output register.
// Throughput: one item per cycle while unstalled; all motion state updates at once.
// The two-entry queue keeps input transfers going while a result waits on the output.
// Reset: motion idle, position, countdown and step count zero, direction negative,
// step interval 1000 ticks; no result pending.
`default_nettype none

module stepper_step_generator_top #(
  parameter int unsigned POS_BITS = ssg_pkg::POS_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         func_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic               run_direction_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    step_pulse_o,
  output logic                    direction_out_o,
  output logic signed [31:0]      actual_position_o,
  output logic                    moving_o,
  output logic [1:0]              event_res_o,
  output logic                    error_o
);

  logic [31:0]    interval_q;
  logic           q_full, head_valid, pop;
  ssg_pkg::push_t push;
  ssg_pkg::cmd_t  head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ssg_pkg::REG_INTERVAL) ? interval_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ssg_pkg::INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == ssg_pkg::REG_INTERVAL) begin
      interval_q <= pwdata;
    end
  end

  ssg_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .value_i         (value_i),
    .run_direction_i (run_direction_i),
    .q_full_i        (q_full),
    .push_o          (push)
  );

  ssg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .full_o       (q_full)
  );

  ssg_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .interval_i        (interval_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .step_pulse_o      (step_pulse_o),
    .direction_out_o   (direction_out_o),
    .actual_position_o (actual_position_o),
    .moving_o          (moving_o),
    .event_res_o       (event_res_o),
    .error_o           (error_o)
  );

endmodule

`default_nettype wire

### tb/stepper_step_generator_top_tb.sv
// Self-checking testbench of the stepper step generator: directed table, then random phases.
module stepper_step_generator_top_tb;

  localparam logic [2:0] FUNC_UNUSED6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED7 = 3'd7;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 6;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int REPORT_LIMIT    = 10;

  typedef enum logic [1:0] {
    MOTION_IDLE,
    MOTION_POSITION,
    MOTION_VELOCITY
  } motion_e;

  typedef struct packed {
    logic        step;
    logic        dir;
    logic [31:0] pos;
    logic        moving;
    logic [1:0]  evt;
    logic        err;
  } step_res_t;

  typedef struct packed {
    logic        is_cfg;
    logic [31:0] cfg_data;
    logic [2:0]  func;
    logic [31:0] value;
    logic        rdir;
    logic        typed_on;
    step_res_t   typed;
  } dir_row_t;

  localparam step_res_t NO_RES = '0;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         func_i;
  logic signed [31:0] value_i;
  logic               run_direction_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic               step_pulse_o;
  logic               direction_out_o;
  logic signed [31:0] actual_position_o;
  logic               moving_o;
  logic [1:0]         event_res_o;
  logic               error_o;

  // Predictor state of the motion engine
  logic [31:0] interval_q;
  logic [31:0] steps_left_q;
  logic [31:0] position_q;
  logic        dir_q;
  motion_e     mode_q;
  logic [31:0] countdown_q;

  step_res_t pending_outputs[$];
  dir_row_t  directed_rows[$];

  // Typed expectation travels alongside the payload of a directed row
  logic      use_typed;
  step_res_t typed_res;

  int mismatch_cnt;
  int cycle_cnt;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  bit hold_req;

  stepper_step_generator_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .value_i           (value_i),
    .run_direction_i   (run_direction_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .step_pulse_o      (step_pulse_o),
    .direction_out_o   (direction_out_o),
    .actual_position_o (actual_position_o),
    .moving_o          (moving_o),
    .event_res_o       (event_res_o),
    .error_o           (error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic step_res_t next_step_outputs(input logic [2:0] f, input logic [31:0] v,
                                                  input logic rd);
    step_res_t   res;
    logic [31:0] count;
    res   = '0;
    count = '0;
    case (f)
      ssg_pkg::FUNC_TICK: begin
        if (mode_q != MOTION_IDLE) begin
          if (countdown_q > 32'd1) begin
            countdown_q = countdown_q - 32'd1;
          end else begin
            res.step    = 1'b1;
            position_q  = dir_q ? position_q + 32'd1 : position_q - 32'd1;
            countdown_q = interval_q;
            if (mode_q == MOTION_POSITION) begin
              steps_left_q = steps_left_q - 32'd1;
              if (steps_left_q == 32'd0) begin
                mode_q      = MOTION_IDLE;
                countdown_q = 32'd0;
                res.evt     = ssg_pkg::EVT_DONE;
              end
            end
          end
        end
      end
      ssg_pkg::FUNC_MOVE_REL, ssg_pkg::FUNC_MOVE_ABS: begin
        count = (f == ssg_pkg::FUNC_MOVE_REL) ? v : v - position_q;
        if (interval_q == 32'd0) begin
          res.err = 1'b1;
        end else if (count == 32'd0) begin
          // zero-length move completes at once and keeps the direction
          mode_q       = MOTION_IDLE;
          steps_left_q = 32'd0;
          countdown_q  = 32'd0;
          res.evt      = ssg_pkg::EVT_DONE;
        end else begin
          dir_q        = ~count[31];
          steps_left_q = count[31] ? -count : count;
          mode_q       = MOTION_POSITION;
          countdown_q  = 32'd1;
        end
      end
      ssg_pkg::FUNC_RUN: begin
        mode_q      = MOTION_VELOCITY;
        dir_q       = rd;
        countdown_q = 32'd1;
      end
      ssg_pkg::FUNC_STOP: begin
        mode_q       = MOTION_IDLE;
        steps_left_q = 32'd0;
        countdown_q  = 32'd0;
        res.evt      = ssg_pkg::EVT_STOPPED;
      end
      ssg_pkg::FUNC_SET_POS: begin
        position_q = v;
      end
      default: ;
    endcase
    res.dir    = dir_q;
    res.pos    = position_q;
    res.moving = (mode_q != MOTION_IDLE);
    return res;
  endfunction

  // Predict on every input transfer
  always @(posedge clk_i) begin
    step_res_t pred;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred = next_step_outputs(func_i, value_i, run_direction_i);
      pending_outputs.push_back(use_typed ? typed_res : pred);
    end
  end

  // Check every output transfer against the oldest expectation
  always @(posedge clk_i) begin
    step_res_t got;
    step_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{step_pulse_o, direction_out_o, actual_position_o, moving_o, event_res_o, error_o};
      if (pending_outputs.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT)
          $display("unexpected result: step=%0b dir=%0b pos=%h moving=%0b event=%0d error=%0b",
                   got.step, got.dir, got.pos, got.moving, got.evt, got.err);
      end else begin
        want = pending_outputs.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT)
            $display({"mismatch: expected step=%0b dir=%0b pos=%h moving=%0b event=%0d error=%0b",
                      " got step=%0b dir=%0b pos=%h moving=%0b event=%0d error=%0b"},
                     want.step, want.dir, want.pos, want.moving, want.evt, want.err,
                     got.step, got.dir, got.pos, got.moving, got.evt, got.err);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [2:0] f, input logic [31:0] v, input logic rd,
                           input logic typed_on, input step_res_t typed);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    value_i         <= v;
    run_direction_i <= rd;
    use_typed       <= typed_on;
    typed_res       <= typed;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_outputs.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    interval_q = data;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    logic [2:0]  f;
    logic [31:0] v;
    logic        rd;
    logic [31:0] ival;
    int          r;

    rst_ni          = 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    func_i          <= ssg_pkg::FUNC_TICK;
    value_i         <= '0;
    run_direction_i <= 1'b0;
    use_typed       <= 1'b0;
    typed_res       <= NO_RES;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_left       = 0;
    hold_req        = 1'b0;

    interval_q   = ssg_pkg::INTERVAL_RESET;
    steps_left_q = '0;
    position_q   = '0;
    dir_q        = 1'b0;
    mode_q       = MOTION_IDLE;
    countdown_q  = '0;

    // Directed rows: reset state, stop while idle, position extremes and wrap,
    // zero-length move, unused codes, run at zero interval, rejected moves, largest interval
    directed_rows = '{
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b1,
        '{1'b0, 1'b0, 32'd0, 1'b0, ssg_pkg::EVT_NONE, 1'b0}},
      '{1'b0, 32'd0, ssg_pkg::FUNC_STOP, 32'd0, 1'b0, 1'b1,
        '{1'b0, 1'b0, 32'd0, 1'b0, ssg_pkg::EVT_STOPPED, 1'b0}},
      '{1'b0, 32'd0, ssg_pkg::FUNC_SET_POS, 32'h7fffffff, 1'b0, 1'b1,
        '{1'b0, 1'b0, 32'h7fffffff, 1'b0, ssg_pkg::EVT_NONE, 1'b0}},
      '{1'b0, 32'd0, ssg_pkg::FUNC_SET_POS, 32'h80000000, 1'b0, 1'b1,
        '{1'b0, 1'b0, 32'h80000000, 1'b0, ssg_pkg::EVT_NONE, 1'b0}},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_REL, 32'd0, 1'b0, 1'b1,
        '{1'b0, 1'b0, 32'h80000000, 1'b0, ssg_pkg::EVT_DONE, 1'b0}},
      '{1'b1, 32'd1, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_REL, 32'hffffffff, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_ABS, 32'h80000000, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'hffffffff, 1'b1, 1'b0, NO_RES},
      '{1'b0, 32'd0, FUNC_UNUSED6, 32'hffffffff, 1'b1, 1'b0, NO_RES},
      '{1'b0, 32'd0, FUNC_UNUSED7, 32'h5a5a5a5a, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_RUN, 32'd0, 1'b1, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_REL, 32'd2, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_SET_POS, 32'd5, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_STOP, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b1, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_SET_POS, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_REL, 32'd5, 1'b0, 1'b1,
        '{1'b0, 1'b1, 32'd0, 1'b0, ssg_pkg::EVT_NONE, 1'b1}},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_ABS, 32'h7fffffff, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_RUN, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_STOP, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b1, 32'hffffffff, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_MOVE_REL, 32'h80000000, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_TICK, 32'd0, 1'b0, 1'b0, NO_RES},
      '{1'b0, 32'd0, ssg_pkg::FUNC_STOP, 32'd0, 1'b0, 1'b0, NO_RES}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_outputs();
        apb_write({ssg_pkg::REG_INTERVAL, 2'b00}, directed_rows[i].cfg_data);
      end else begin
        send_item(directed_rows[i].func, directed_rows[i].value, directed_rows[i].rdir,
                  directed_rows[i].typed_on, directed_rows[i].typed);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin ival = 32'd1; send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin ival = 32'd2; send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin ival = 32'd3; send_idle_pct = 0;  recv_stall_pct = 87; end
        3: begin ival = 32'd0; send_idle_pct = 23; recv_stall_pct = 23; end
        4: begin ival = 32'd1; send_idle_pct = 0;  recv_stall_pct = 0;  end
        default: begin ival = 32'd4; send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      drain_outputs();
      apb_write({ssg_pkg::REG_INTERVAL, 2'b00}, ival);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) begin
          // pause the sender until the pipeline is empty
          in_valid_i <= 1'b0;
          do @(negedge clk_i); while (pending_outputs.size() != 0);
        end
        if (ph == 4 && n == 10)
          hold_req = 1'b1;
        rd = $urandom_range(1);
        v  = $urandom;
        r  = $urandom_range(99);
        if (r < 50) begin
          f = ssg_pkg::FUNC_TICK;
        end else if (r < 62) begin
          f = ssg_pkg::FUNC_MOVE_REL;
          r = $urandom_range(9);
          if (r < 7) begin
            v = $urandom_range(1, 6);
            if (rd)
              v = -v;
          end else if (r < 8) begin
            v = 32'd0;
          end
        end else if (r < 70) begin
          f = ssg_pkg::FUNC_MOVE_ABS;
          if ($urandom_range(3) != 0)
            v = position_q + $urandom_range(0, 12) - 32'd6;
        end else if (r < 76) begin
          f = ssg_pkg::FUNC_RUN;
        end else if (r < 81) begin
          f = ssg_pkg::FUNC_STOP;
        end else if (r < 87) begin
          f = ssg_pkg::FUNC_SET_POS;
          // land near the signed wrap point now and then
          if ($urandom_range(1))
            v = 32'h7ffffffc + $urandom_range(0, 7);
        end else if (r < 90) begin
          f = $urandom_range(1) ? FUNC_UNUSED7 : FUNC_UNUSED6;
        end else begin
          f = ssg_pkg::FUNC_TICK;
        end
        send_item(f, v, rd, 1'b0, NO_RES);
      end
    end

    drain_outputs();
    repeat (10) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_outputs.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
